@@ src/jse_pkg.sv @@
// Shared types, character codes and helpers for the JSON string escaper.
package jse_pkg;

    // Token queue between the front and back sections
    localparam int TOK_DEPTH = 4;
    localparam int TOK_PTR_W = $clog2(TOK_DEPTH);

    // Character codes
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;

    // Token kinds: raw byte, byte that may need an escape, backslash-u of a value
    typedef enum logic [1:0] {
        TK_RAW = 2'd0,
        TK_ESC = 2'd1,
        TK_HEX = 2'd2
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t   kind;
        logic [15:0] val;
        logic        last;
    } tok_t;

    typedef struct packed {
        logic push;
        tok_t tok;
    } tok_wr_t;

    typedef struct packed {
        logic empty;
        tok_t tok;
    } tok_rd_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] d;
        if (nib < 4'd10)
        begin
            d = 8'h30 + {4'd0, nib};
        end
        else
        begin
            d = 8'h57 + {4'd0, nib};
        end
        return d;
    endfunction

endpackage

@@ src/jse_front.sv @@
// Front section: accepts bytes, runs the UTF-8 lookahead and issues tokens.
module jse_front
    import jse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  logic [7:0] data_byte,
    input  logic       has_byte,
    input  logic       start_of_string,
    input  logic       end_of_string,
    input  logic       q_full,
    output tok_wr_t    q_wr
);

    typedef enum logic [1:0] {
        FR_IDLE = 2'b01,
        FR_WORK = 2'b10
    } fr_state_t;

    fr_state_t   state_reg, state_next;
    logic [7:0]  la_reg [4];
    logic [7:0]  la_next [4];
    logic [2:0]  cnt_reg, cnt_next;
    logic        open_reg, open_next;
    logic        fin_reg, fin_next;
    logic [1:0]  pass_reg, pass_next;
    tok_t        hold_reg, hold_next;
    logic        hold_vld_reg, hold_vld_next;

    // head decode
    logic [7:0]  h;
    logic [1:0]  ext;
    logic [3:1]  cont;
    logic        window;
    logic [20:0] cp;
    logic        surr;
    tok_t        dec_tok;
    logic [2:0]  dec_use;
    logic [1:0]  dec_pass;
    logic        dec_break;

    assign item_stall = (state_reg != FR_IDLE);

    always_comb
    begin
        h       = la_reg[0];
        cont[1] = (la_reg[1][7:6] == 2'b10);
        cont[2] = (la_reg[2][7:6] == 2'b10);
        cont[3] = (la_reg[3][7:6] == 2'b10);

        if (h[7:5] == 3'b110)
        begin
            ext = 2'd1;
        end
        else if (h[7:4] == 4'b1110)
        begin
            ext = 2'd2;
        end
        else if (h[7:3] == 5'b11110)
        begin
            ext = 2'd3;
        end
        else
        begin
            ext = 2'd0;
        end

        case (ext)
            2'd1:    cp = {10'd0, h[4:0], la_reg[1][5:0]};
            2'd2:    cp = {5'd0, h[3:0], la_reg[1][5:0], la_reg[2][5:0]};
            2'd3:    cp = {h[2:0], la_reg[1][5:0], la_reg[2][5:0], la_reg[3][5:0]};
            default: cp = '0;
        endcase
        surr   = (cp[20:16] == 5'd0) && (cp[15:11] == 5'b11011);
        window = ({1'b0, ext} < cnt_reg);

        dec_tok   = '{kind: TK_RAW, val: {8'd0, h}, last: 1'b0};
        dec_use   = 3'd1;
        dec_pass  = 2'd0;
        dec_break = 1'b0;

        if (!h[7])
        begin
            dec_tok.kind = TK_ESC;
        end
        else if (ext == 2'd0)
        begin
            dec_use = 3'd1;
        end
        else if (window)
        begin
            if (!cont[1])
            begin
                dec_use = 3'd1;
            end
            else if ((ext >= 2'd2) && !cont[2])
            begin
                dec_use = 3'd2;
            end
            else if ((ext == 2'd3) && !cont[3])
            begin
                dec_use = 3'd3;
            end
            else if (surr)
            begin
                dec_tok.kind = TK_HEX;
                dec_tok.val  = cp[15:0];
                dec_use      = {1'b0, ext} + 3'd1;
            end
            else
            begin
                // pass the whole sequence through, one byte at a time
                dec_pass = ext;
            end
        end
        else if (fin_reg)
        begin
            dec_use = 3'd1;
        end
        else if ((cnt_reg > 3'd1) && !cont[1])
        begin
            dec_use = 3'd1;
        end
        else
        begin
            dec_break = 1'b1;
        end
    end

    always_comb
    begin
        logic [2:0] base;
        logic [2:0] sidx;
        logic [2:0] use_n;
        logic       gen;
        tok_t       gen_tok;

        state_next    = state_reg;
        la_next       = la_reg;
        cnt_next      = cnt_reg;
        open_next     = open_reg;
        fin_next      = fin_reg;
        pass_next     = pass_reg;
        hold_next     = hold_reg;
        hold_vld_next = hold_vld_reg;
        q_wr          = '{push: 1'b0, tok: hold_reg};
        base          = start_of_string ? 3'd0 : cnt_reg;
        sidx          = '0;
        use_n         = '0;
        gen           = 1'b0;
        gen_tok       = '{kind: TK_RAW, val: {8'd0, CH_QUOTE}, last: 1'b0};

        case (state_reg)
            FR_IDLE:
            begin
                if (item_valid)
                begin
                    if (has_byte)
                    begin
                        la_next[base[1:0]] = data_byte;
                    end
                    cnt_next   = base + {2'd0, has_byte};
                    open_next  = start_of_string;
                    fin_next   = end_of_string;
                    pass_next  = 2'd0;
                    state_next = FR_WORK;
                end
            end
            FR_WORK:
            begin
                if (open_reg)
                begin
                    gen = 1'b1;
                end
                else if (pass_reg != 2'd0)
                begin
                    gen     = 1'b1;
                    gen_tok = '{kind: TK_RAW, val: {8'd0, la_reg[0]}, last: 1'b0};
                    use_n   = 3'd1;
                end
                else if ((cnt_reg != 3'd0) && !dec_break)
                begin
                    gen     = 1'b1;
                    gen_tok = dec_tok;
                    use_n   = dec_use;
                end
                else if (fin_reg)
                begin
                    gen = 1'b1;
                end

                if (gen)
                begin
                    if (!hold_vld_reg || !q_full)
                    begin
                        q_wr.push     = hold_vld_reg;
                        hold_next     = gen_tok;
                        hold_vld_next = 1'b1;
                        if (open_reg)
                        begin
                            open_next = 1'b0;
                        end
                        else if (pass_reg != 2'd0)
                        begin
                            pass_next = pass_reg - 2'd1;
                        end
                        else if (use_n != 3'd0)
                        begin
                            pass_next = dec_pass;
                        end
                        else
                        begin
                            fin_next = 1'b0;
                            cnt_next = 3'd0;
                        end
                        // drop the settled bytes from the head of the lookahead
                        if (use_n != 3'd0)
                        begin
                            cnt_next = cnt_reg - use_n;
                            for (int i = 0; i < 4; i++)
                            begin
                                sidx = 3'(i) + use_n;
                                if (sidx < 3'd4)
                                begin
                                    la_next[i] = la_reg[sidx[1:0]];
                                end
                            end
                        end
                    end
                end
                else if (!hold_vld_reg)
                begin
                    state_next = FR_IDLE;
                end
                else if (!q_full)
                begin
                    q_wr.push     = 1'b1;
                    q_wr.tok.last = 1'b1;
                    hold_vld_next = 1'b0;
                    state_next    = FR_IDLE;
                end
            end
            default:
            begin
                state_next = FR_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= FR_IDLE;
            cnt_reg      <= '0;
            open_reg     <= 1'b0;
            fin_reg      <= 1'b0;
            pass_reg     <= '0;
            hold_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            open_reg     <= open_next;
            fin_reg      <= fin_next;
            pass_reg     <= pass_next;
            hold_vld_reg <= hold_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        la_reg   <= la_next;
        hold_reg <= hold_next;
    end

endmodule

@@ src/jse_tok_fifo.sv @@
// Token queue between the front and back sections.
module jse_tok_fifo
    import jse_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  tok_wr_t wr,
    output logic    full,
    input  logic    pop,
    output tok_rd_t rd
);

    tok_t                 mem_reg [TOK_DEPTH];
    logic [TOK_PTR_W-1:0] wp_reg, wp_next;
    logic [TOK_PTR_W-1:0] rp_reg, rp_next;
    logic [TOK_PTR_W:0]   cnt_reg, cnt_next;
    logic                 do_push;
    logic                 do_pop;

    assign full     = (cnt_reg == (TOK_PTR_W+1)'(TOK_DEPTH));
    assign rd.empty = (cnt_reg == '0);
    assign rd.tok   = mem_reg[rp_reg];
    assign do_push  = wr.push && !full;
    assign do_pop   = pop && !rd.empty;

    always_comb
    begin
        wp_next  = do_push ? wp_reg + 1'b1 : wp_reg;
        rp_next  = do_pop ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg + {{TOK_PTR_W{1'b0}}, do_push} - {{TOK_PTR_W{1'b0}}, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wp_reg] <= wr.tok;
        end
    end

endmodule

@@ src/jse_back.sv @@
// Back section: expands tokens into escaped characters behind an output register.
module jse_back
    import jse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  tok_rd_t    q_rd,
    output logic       q_pop,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [7:0] out_char,
    output logic       last_of_run
);

    typedef enum logic [1:0] {
        MD_SINGLE = 2'd0,
        MD_PAIR   = 2'd1,
        MD_HEX    = 2'd2
    } mode_t;

    logic        cur_vld_reg, cur_vld_next;
    mode_t       mode_reg, mode_next;
    logic [15:0] val_reg, val_next;
    logic        cur_last_reg, cur_last_next;
    logic [2:0]  idx_reg, idx_next;
    logic        out_vld_reg;
    logic [7:0]  out_char_reg;
    logic        out_last_reg;

    logic        out_load;
    logic        emit;
    logic        at_end;
    logic [7:0]  ch;
    logic [7:0]  tb;

    assign result_valid = out_vld_reg;
    assign out_char     = out_char_reg;
    assign last_of_run  = out_last_reg;

    assign out_load = !out_vld_reg || !result_stall;
    assign emit     = cur_vld_reg && out_load;
    assign q_pop    = !q_rd.empty && (!cur_vld_reg || (emit && at_end));
    assign tb       = q_rd.tok.val[7:0];

    // character at the current position of the token being expanded
    always_comb
    begin
        case (mode_reg)
            MD_SINGLE:
            begin
                ch     = val_reg[7:0];
                at_end = 1'b1;
            end
            MD_PAIR:
            begin
                ch     = (idx_reg == 3'd0) ? CH_BSLASH : val_reg[7:0];
                at_end = (idx_reg == 3'd1);
            end
            MD_HEX:
            begin
                at_end = (idx_reg == 3'd5);
                case (idx_reg)
                    3'd0:    ch = CH_BSLASH;
                    3'd1:    ch = CH_U;
                    3'd2:    ch = hex_digit(val_reg[15:12]);
                    3'd3:    ch = hex_digit(val_reg[11:8]);
                    3'd4:    ch = hex_digit(val_reg[7:4]);
                    default: ch = hex_digit(val_reg[3:0]);
                endcase
            end
            default:
            begin
                ch     = val_reg[7:0];
                at_end = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        cur_vld_next  = cur_vld_reg;
        mode_next     = mode_reg;
        val_next      = val_reg;
        cur_last_next = cur_last_reg;
        idx_next      = idx_reg;

        if (q_pop)
        begin
            cur_vld_next  = 1'b1;
            cur_last_next = q_rd.tok.last;
            idx_next      = 3'd0;
            mode_next     = MD_SINGLE;
            val_next      = {8'd0, tb};
            case (q_rd.tok.kind)
                TK_RAW:
                begin
                    mode_next = MD_SINGLE;
                end
                TK_HEX:
                begin
                    mode_next = MD_HEX;
                    val_next  = q_rd.tok.val;
                end
                TK_ESC:
                begin
                    case (tb)
                        CH_QUOTE:  mode_next = MD_PAIR;
                        CH_BSLASH: mode_next = MD_PAIR;
                        CH_BS:
                        begin
                            mode_next = MD_PAIR;
                            val_next  = {8'd0, CH_B};
                        end
                        CH_FF:
                        begin
                            mode_next = MD_PAIR;
                            val_next  = {8'd0, CH_F};
                        end
                        CH_LF:
                        begin
                            mode_next = MD_PAIR;
                            val_next  = {8'd0, CH_N};
                        end
                        CH_CR:
                        begin
                            mode_next = MD_PAIR;
                            val_next  = {8'd0, CH_R};
                        end
                        CH_TAB:
                        begin
                            mode_next = MD_PAIR;
                            val_next  = {8'd0, CH_T};
                        end
                        default:
                        begin
                            if (tb inside {[8'h00:8'h1F]})
                            begin
                                mode_next = MD_HEX;
                            end
                        end
                    endcase
                end
                default:
                begin
                    mode_next = MD_SINGLE;
                end
            endcase
        end
        else if (emit && at_end)
        begin
            cur_vld_next = 1'b0;
        end
        else if (emit)
        begin
            idx_next = idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            cur_vld_reg <= cur_vld_next;
            if (out_load)
            begin
                out_vld_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        val_reg      <= val_next;
        cur_last_reg <= cur_last_next;
        idx_reg      <= idx_next;
        if (emit)
        begin
            out_char_reg <= ch;
            out_last_reg <= cur_last_reg && at_end;
        end
    end

endmodule

@@ src/json_string_escaper.sv @@
// Top level of the JSON string escaper: front section, token queue, back section.
//
// Usage:
//   The item channel (item_valid / item_stall) takes one string byte per
//   transaction with its flags: has_byte, start_of_string (emit the opening
//   quote, drop any held bytes) and end_of_string (flush, emit the closing quote).
//   The result channel (result_valid / result_stall) carries one byte of JSON
//   text per transaction; last_of_run marks the final byte caused by an item.
//   An item that causes nothing yields no result transaction.
// Flow:
//   The front section raises item_stall while it settles an item into tokens
//   (quotes, plain or escaped bytes, backslash-u escapes) and takes no new item
//   until it is done; the back section emits one character per cycle while
//   result_stall is low.
// Reset:
//   rst_n clears the lookahead count, the token queue and the output register.
// Stall:
//   While result_stall is high the output register holds its byte, the back
//   section stops popping, the four-entry token queue fills and the front
//   section raises item_stall until space frees up.
module json_string_escaper
    import jse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  logic [7:0] data_byte,
    input  logic       has_byte,
    input  logic       start_of_string,
    input  logic       end_of_string,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [7:0] out_char,
    output logic       last_of_run
);

    tok_wr_t q_wr;
    tok_rd_t q_rd;
    logic    q_full;
    logic    q_pop;

    // Classify bytes, hold partial UTF-8 sequences, issue tokens
    jse_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .data_byte       (data_byte),
        .has_byte        (has_byte),
        .start_of_string (start_of_string),
        .end_of_string   (end_of_string),
        .q_full          (q_full),
        .q_wr            (q_wr)
    );

    // Decouple token production from character output
    jse_tok_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .full  (q_full),
        .pop   (q_pop),
        .rd    (q_rd)
    );

    // Expand tokens into escaped text, one character per cycle while result_stall is low
    jse_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_rd         (q_rd),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_char     (out_char),
        .last_of_run  (last_of_run)
    );

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the JSON string escaper: directed and random strings.
`timescale 1ns / 100ps

module tb_top;
    import jse_pkg::*;

    // Run limits
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_RUN      = 20;
    localparam int RANDOM_ITEMS = 80;
    localparam int REPORT_LIMIT = 10;
    localparam logic [7:0] CTRL_LIMIT = 8'd32;

    // One expected byte of JSON text with its end-of-run mark
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_char_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       item_valid = 1'b0;
    logic       item_stall;
    logic [7:0] data_byte = 8'h00;
    logic       has_byte = 1'b0;
    logic       start_of_string = 1'b0;
    logic       end_of_string = 1'b0;
    logic       result_valid;
    logic       result_stall = 1'b0;
    logic [7:0] out_char;
    logic       last_of_run;

    // Escaper state as the predictor sees it
    logic [7:0] held_bytes [3];
    int         held_count = 0;
    logic [7:0] window [4];
    logic [7:0] run_chars [$];

    // JSON text still owed by the block, oldest first
    text_char_t expected_text [$];

    // Bytes of the string being built by a test
    logic [7:0] draft [$];

    int  cycle_count = 0;
    int  failures = 0;
    int  mismatch_count = 0;
    int  items_sent = 0;
    bit  sender_steady = 1'b0;
    bit  receiver_steady = 1'b0;
    int  receiver_left = 0;

    json_string_escaper dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .data_byte       (data_byte),
        .has_byte        (has_byte),
        .start_of_string (start_of_string),
        .end_of_string   (end_of_string),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .out_char        (out_char),
        .last_of_run     (last_of_run)
    );

    always #5 clk = ~clk;

    // Watchdog: a hung handshake ends the run as a failure
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d bytes still owed", cycle_count,
                     expected_text.size());
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [7:0] rand_byte(input int lo, input int hi);
        return 8'($urandom_range(hi, lo));
    endfunction

    // Add one byte at the tail of the draft string
    function automatic void append_draft(input logic [7:0] b);
        draft = {draft, b};
    endfunction

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Append one output byte to the current run; one item never yields more than MAX_RUN
    function automatic void put_text(input logic [7:0] c);
        if (run_chars.size() < MAX_RUN)
        begin
            run_chars = {run_chars, c};
        end
    endfunction

    // Backslash-u with four lowercase hex digits, most significant first
    function automatic void put_hex_escape(input logic [15:0] v);
        logic [3:0] nib;
        put_text(CH_BSLASH);
        put_text(CH_U);
        for (int i = 3; i >= 0; i--)
        begin
            nib = v[i*4 +: 4];
            put_text((nib < 4'd10) ? 8'h30 + {4'd0, nib} : 8'h57 + {4'd0, nib});
        end
    endfunction

    // Escape one ASCII byte: quote, backslash and the five named controls get
    // a short escape, any other control byte gets backslash-u
    function automatic void put_plain(input logic [7:0] ch);
        case (ch)
            CH_QUOTE:  begin put_text(CH_BSLASH); put_text(CH_QUOTE);  end
            CH_BSLASH: begin put_text(CH_BSLASH); put_text(CH_BSLASH); end
            CH_BS:     begin put_text(CH_BSLASH); put_text(CH_B);      end
            CH_FF:     begin put_text(CH_BSLASH); put_text(CH_F);      end
            CH_LF:     begin put_text(CH_BSLASH); put_text(CH_N);      end
            CH_CR:     begin put_text(CH_BSLASH); put_text(CH_R);      end
            CH_TAB:    begin put_text(CH_BSLASH); put_text(CH_T);      end
            default:
            begin
                if (ch < CTRL_LIMIT)
                begin
                    put_hex_escape({8'd0, ch});
                end
                else
                begin
                    put_text(ch);
                end
            end
        endcase
    endfunction

    // Decode window[0..n-1] and return how many bytes are settled. Bytes past
    // that point stay in the lookahead until their sequence can be judged.
    function automatic int settle_window(input int n, input bit closing);
        int         p;
        int         extra;
        int         k;
        bit         bad;
        bit         hold;
        logic [7:0] ch;
        logic [20:0] cp;
        p = 0;
        hold = 1'b0;
        while (p < n && !hold)
        begin
            ch = window[p];
            extra = 0;
            cp = '0;
            if (ch < 8'h80)
            begin
                put_plain(ch);
                p++;
                continue;
            end
            if ((ch & 8'hE0) == 8'hC0)
            begin
                cp = {13'd0, ch & 8'h1F};
                extra = 1;
            end
            else if ((ch & 8'hF0) == 8'hE0)
            begin
                cp = {13'd0, ch & 8'h0F};
                extra = 2;
            end
            else if ((ch & 8'hF8) == 8'hF0)
            begin
                cp = {13'd0, ch & 8'h07};
                extra = 3;
            end

            if (extra == 0)
            begin
                // Stray continuation or a byte from F8 up: pass it raw
                put_text(ch);
                p++;
            end
            else if (p + extra < n)
            begin
                // Whole window present: a bad continuation drops the good ones
                // before it and decoding resumes at the bad byte
                bad = 1'b0;
                k = 1;
                while (k <= extra && !bad)
                begin
                    if ((window[p+k] & 8'hC0) != 8'h80)
                    begin
                        bad = 1'b1;
                    end
                    else
                    begin
                        cp = (cp << 6) | {15'd0, window[p+k][5:0]};
                        k++;
                    end
                end
                if (bad)
                begin
                    put_text(ch);
                    p += k;
                end
                else
                begin
                    if (cp >= 21'h0D800 && cp <= 21'h0DFFF)
                    begin
                        put_hex_escape(cp[15:0]);
                    end
                    else
                    begin
                        for (k = 0; k <= extra; k++)
                        begin
                            put_text(window[p+k]);
                        end
                    end
                    p += extra + 1;
                end
            end
            else if (closing)
            begin
                // Sequence cut by the end of the string
                put_text(ch);
                p++;
            end
            else if (p + 1 < n && (window[p+1] & 8'hC0) != 8'h80)
            begin
                // Next byte already breaks the sequence
                put_text(ch);
                p++;
            end
            else
            begin
                hold = 1'b1;
            end
        end
        return p;
    endfunction

    // Work out the JSON text one accepted transaction causes and queue it
    task automatic predict_item(input logic [7:0] data, input bit has, input bit sos,
                                input bit eos);
        int         n;
        int         used;
        int         rem;
        text_char_t e;
        run_chars.delete();
        n = 0;
        if (sos)
        begin
            held_count = 0;
            put_text(CH_QUOTE);
        end
        for (int i = 0; i < held_count; i++)
        begin
            window[n] = held_bytes[i];
            n++;
        end
        if (has)
        begin
            window[n] = data;
            n++;
        end
        used = settle_window(n, eos);
        rem = n - used;
        if (rem < 0) rem = 0;
        if (rem > 3) rem = 3;
        for (int i = 0; i < rem; i++)
        begin
            held_bytes[i] = window[n-rem+i];
        end
        held_count = rem;
        if (eos)
        begin
            held_count = 0;
            put_text(CH_QUOTE);
        end
        for (int i = 0; i < run_chars.size(); i++)
        begin
            e.ch = run_chars[i];
            e.last = (i == run_chars.size() - 1);
            expected_text = {expected_text, e};
        end
    endtask

    // ------------------------------------------------------------------
    // Item side
    // ------------------------------------------------------------------

    // Send one transaction after a random gap; predict it once it is taken.
    // Valid stays high after acceptance so back-to-back items see no bubble.
    task automatic send_item(input logic [7:0] data, input bit has, input bit sos,
                             input bit eos);
        int gap;
        gap = sender_steady ? 0 : $urandom_range(0, 7);
        repeat (gap)
        begin
            @(negedge clk);
            item_valid <= 1'b0;
        end
        @(negedge clk);
        item_valid      <= 1'b1;
        data_byte       <= data;
        has_byte        <= has;
        start_of_string <= sos;
        end_of_string   <= eos;
        @(posedge clk);
        while (item_stall)
        begin
            @(posedge clk);
        end
        predict_item(data, has, sos, eos);
        items_sent++;
    endtask

    task automatic release_items();
        @(negedge clk);
        item_valid <= 1'b0;
    endtask

    // Hold off the sender until the block has delivered everything owed
    task automatic wait_drained();
        release_items();
        while (expected_text.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Send the draft as one string; optionally open or close it with a byte-less item
    task automatic send_draft(input bit empty_open, input bit empty_close);
        int last_idx;
        last_idx = draft.size() - 1;
        if (empty_open)
        begin
            send_item(rand_byte(0, 255), 1'b0, 1'b1, 1'b0);
        end
        for (int i = 0; i <= last_idx; i++)
        begin
            send_item(draft[i], 1'b1, !empty_open && i == 0, !empty_close && i == last_idx);
        end
        if (empty_close)
        begin
            send_item(rand_byte(0, 255), 1'b0, 1'b0, 1'b1);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random stall, then check each transaction in order
    // ------------------------------------------------------------------
    initial
    begin
        int         wait_cycles;
        text_char_t want;
        @(posedge rst_n);
        forever
        begin
            // Pick a stalling or a steady stretch anew every 30 bytes
            if (receiver_left == 0)
            begin
                receiver_steady = ($urandom_range(0, 3) == 0);
                receiver_left = 30;
            end
            receiver_left--;
            wait_cycles = receiver_steady ? 0 : $urandom_range(0, 7);
            repeat (wait_cycles)
            begin
                @(negedge clk);
                result_stall <= 1'b1;
            end
            @(negedge clk);
            result_stall <= 1'b0;
            @(posedge clk);
            while (!result_valid)
            begin
                @(posedge clk);
            end
            if (expected_text.size() == 0)
            begin
                failures++;
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                begin
                    $display("cycle %0d: unexpected byte %02h last %0b", cycle_count,
                             out_char, last_of_run);
                end
            end
            else
            begin
                want = expected_text.pop_front();
                if (out_char !== want.ch || last_of_run !== want.last)
                begin
                    failures++;
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                    begin
                        $display("cycle %0d: expected byte %02h last %0b, got %02h last %0b",
                                 cycle_count, want.ch, want.last, out_char, last_of_run);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every short escape, the control-byte extremes, an invalid lead and a stray continuation
    task automatic test_escapes();
        draft = '{8'h00, CH_QUOTE, CH_BSLASH, CH_BS, CH_FF, CH_LF, CH_CR, CH_TAB,
                  8'h1F, 8'hFF, 8'h80};
        send_draft(1'b0, 1'b0);
        wait_drained();
    endtask

    // Surrogate code point, a valid four-byte sequence and an overlong pair
    task automatic test_multibyte();
        draft = '{8'hED, 8'hA0, 8'h80, 8'hF0, 8'h9F, 8'h98, 8'h80, 8'hC0, 8'h80};
        send_draft(1'b0, 1'b0);
        wait_drained();
    endtask

    // Bad continuation, unterminated string, byte-less items, cut sequence
    task automatic test_broken_sequences();
        send_item(8'hE2, 1'b1, 1'b1, 1'b0);
        send_item(8'h82, 1'b1, 1'b0, 1'b0);
        send_item(8'h41, 1'b1, 1'b0, 1'b0);
        // Leave a lead byte held, then open a new string over it
        send_item(8'hF0, 1'b1, 1'b0, 1'b0);
        send_item(8'hE2, 1'b1, 1'b1, 1'b0);
        send_item(8'h82, 1'b1, 1'b0, 1'b0);
        // No byte and no flag: nothing comes out
        send_item(8'h5A, 1'b0, 1'b0, 1'b0);
        // Close with the sequence cut short
        send_item(8'hA5, 1'b0, 1'b0, 1'b1);
        // Empty string
        send_item(8'hFF, 1'b0, 1'b1, 1'b1);
        wait_drained();
    endtask

    // Append one random piece of string text to the draft
    task automatic add_fragment();
        int kind;
        int conts;
        kind = $urandom_range(0, 11);
        case (kind)
            0, 1: append_draft(rand_byte(8'h20, 8'h7E));
            2:
            begin
                case ($urandom_range(0, 6))
                    0: append_draft(CH_QUOTE);
                    1: append_draft(CH_BSLASH);
                    2: append_draft(CH_BS);
                    3: append_draft(CH_FF);
                    4: append_draft(CH_LF);
                    5: append_draft(CH_CR);
                    default: append_draft(CH_TAB);
                endcase
            end
            3: append_draft(rand_byte(0, 31));
            4:
            begin
                append_draft(8'hC0 | rand_byte(0, 31));
                append_draft(8'h80 | rand_byte(0, 63));
            end
            5:
            begin
                append_draft(8'hE0 | rand_byte(0, 15));
                append_draft(8'h80 | rand_byte(0, 63));
                append_draft(8'h80 | rand_byte(0, 63));
            end
            6:
            begin
                // Lands in the surrogate range
                append_draft(8'hED);
                append_draft(8'hA0 | rand_byte(0, 31));
                append_draft(8'h80 | rand_byte(0, 63));
            end
            7:
            begin
                append_draft(8'hF0 | rand_byte(0, 7));
                repeat (3) append_draft(8'h80 | rand_byte(0, 63));
            end
            8: append_draft(($urandom_range(0, 1) == 0) ? rand_byte(8'h80, 8'hBF)
                                                       : rand_byte(8'hF8, 8'hFF));
            9, 10:
            begin
                // Short sequence: the end, or a next fragment that does not open with a continuation byte, breaks it
                conts = $urandom_range(0, 2);
                append_draft((conts == 2) ? 8'hF0 | rand_byte(0, 7)
                                          : 8'hE0 | rand_byte(0, 15));
                repeat (conts) append_draft(8'h80 | rand_byte(0, 63));
            end
            default: append_draft(rand_byte(0, 255));
        endcase
    endtask

    // Mostly well-formed strings with random content; some noise items in between
    task automatic test_random_strings();
        int goal;
        int pieces;
        goal = items_sent + RANDOM_ITEMS;
        while (items_sent < goal)
        begin
            sender_steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 6) == 0)
            begin
                // Noise: any flags, any byte; may leave a string open
                send_item(rand_byte(0, 255), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
            else
            begin
                draft.delete();
                pieces = $urandom_range(1, 5);
                repeat (pieces) add_fragment();
                send_draft($urandom_range(0, 7) == 0, $urandom_range(0, 5) == 0);
            end
            // Drain fully now and then
            if ($urandom_range(0, 9) == 0)
            begin
                wait_drained();
            end
        end
        sender_steady = 1'b0;
        // Close whatever a noise item left open
        send_item(rand_byte(0, 255), 1'b0, 1'b0, 1'b1);
    endtask

    initial
    begin
        for (int i = 0; i < 3; i++) held_bytes[i] = 8'h00;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_escapes();
        test_multibyte();
        test_broken_sequences();
        test_random_strings();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_text.size() != 0)
        begin
            failures++;
            $display("%0d expected bytes never arrived", expected_text.size());
        end
        if (failures == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
